[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files of the ack collection table.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/act_pkg.sv]
// Package of the ack collection table: sizes, codes and shared structs.
// No dependencies; act_ctl and ack_collection_table import it.
package act_pkg;

  localparam int TableSlots = 16;
  localparam int Devices    = 4;

  localparam int SlotW   = $clog2(TableSlots);
  localparam int DevIdxW = (Devices > 1) ? $clog2(Devices) : 1;
  localparam int IssMax  = (TableSlots > Devices) ? TableSlots : Devices;
  localparam int IssW    = $clog2(IssMax + 1);

  localparam int IdW   = 16;
  localparam int PidW  = 22;
  localparam int TsW   = 32;
  localparam int CntW  = 5;
  localparam int DatW  = 2 * PidW + TsW;

  localparam int InDataW  = 96;
  localparam int OutDataW = 104;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActQuery = 2'd1;
  localparam logic [1:0] ActSweep = 2'd2;

  localparam logic [1:0] KindWrite  = 2'd0;
  localparam logic [1:0] KindQuery  = 2'd1;
  localparam logic [1:0] KindGather = 2'd2;
  localparam logic [1:0] KindEnd    = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic            write_ok;
    logic [CntW-1:0] id_count;
    logic            pair_present;
    logic [IdW-1:0]  group_id;
    logic [PidW-1:0] sender;
    logic [PidW-1:0] receiver;
    logic [TsW-1:0]  timestamp;
    logic            group_last;
    logic            last;
  } res_t;

  typedef struct packed {
    logic             id_we;
    logic             dat_we;
    logic [SlotW-1:0] waddr;
    logic [SlotW-1:0] raddr;
    logic [IdW-1:0]   id_wdata;
    logic [DatW-1:0]  dat_wdata;
  } mem_req_t;

endpackage

[hdl/act_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module act_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/act_ctl.sv]
// Sequencer of the ack collection table: scans, gathers and frees slots.
// Depends on act_pkg and assert_macros.svh; drives the two table RAMs.
`include "assert_macros.svh"
module act_ctl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             in_action_i,
  input  logic [act_pkg::IdW-1:0]  in_id_i,
  input  logic [act_pkg::PidW-1:0] in_snd_i,
  input  logic [act_pkg::PidW-1:0] in_rcv_i,
  input  logic [act_pkg::TsW-1:0]  in_ts_i,
  output act_pkg::mem_req_t      mem_o,
  input  logic [act_pkg::IdW-1:0]  id_rdata_i,
  input  logic [act_pkg::DatW-1:0] dat_rdata_i,
  input  logic                   out_free_i,
  output logic                   push_o,
  output act_pkg::res_t          res_o
);
  import act_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SWScan  = 4'd1;
  localparam logic [3:0] SWStore = 4'd2;
  localparam logic [3:0] SQScan  = 4'd3;
  localparam logic [3:0] SQDone  = 4'd4;
  localparam logic [3:0] SGet    = 4'd5;
  localparam logic [3:0] SGChk   = 4'd6;
  localparam logic [3:0] SGScan  = 4'd7;
  localparam logic [3:0] SSel    = 4'd8;
  localparam logic [3:0] SEmit   = 4'd9;
  localparam logic [3:0] SEnd    = 4'd10;

  logic [3:0]            state_q, state_d;
  logic [IssW-1:0]       iss_q, iss_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [IssW-1:0]       chk_idx_q, chk_idx_d;
  logic [SlotW-1:0]      rd_addr_q;
  logic [TableSlots-1:0] vld_q, vld_d;
  logic [IdW-1:0]        id_q, id_d;
  logic [PidW-1:0]       snd_q, snd_d, rcv_q, rcv_d;
  logic [TsW-1:0]        ts_q, ts_d;
  logic                  free_fnd_q, free_fnd_d;
  logic [SlotW-1:0]      free_slot_q, free_slot_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pair_q, pair_d;
  logic [SlotW-1:0]      cand_q, cand_d;
  logic                  prior_q, prior_d;
  logic [SlotW-1:0]      list_q [Devices];
  logic [SlotW-1:0]      list_d [Devices];
  logic [Devices-1:0]    rem_q, rem_d;
  logic                  best_vld_q, best_vld_d;
  logic [SlotW-1:0]      best_slot_q, best_slot_d;
  logic [DevIdxW-1:0]    best_k_q, best_k_d;
  logic [PidW-1:0]       best_snd_q, best_snd_d, best_rcv_q, best_rcv_d;
  logic [TsW-1:0]        best_ts_q, best_ts_d;
  logic [IssW-1:0]       emit_q, emit_d;

  logic [IdW-1:0]   id_eff;
  logic [PidW-1:0]  rd_snd, rd_rcv;
  logic [TsW-1:0]   rd_ts;
  logic             slot_iss_more, sel_iss_more;
  logic             cand_last;
  logic [DevIdxW-1:0] k_chk;

  assign id_eff  = vld_q[rd_addr_q] ? id_rdata_i : '0;
  assign rd_snd  = dat_rdata_i[DatW-1 -: PidW];
  assign rd_rcv  = dat_rdata_i[TsW +: PidW];
  assign rd_ts   = dat_rdata_i[TsW-1:0];
  assign slot_iss_more = iss_q < IssW'(TableSlots);
  assign sel_iss_more  = iss_q < IssW'(Devices);
  assign cand_last = cand_q == SlotW'(TableSlots - 1);
  assign k_chk = chk_idx_q[DevIdxW-1:0];
  assign in_ready_o = state_q == SIdle;

  always_comb begin
    state_d = state_q;   iss_d = iss_q;       chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q; vld_d = vld_q;     id_d = id_q;
    snd_d = snd_q;       rcv_d = rcv_q;       ts_d = ts_q;
    free_fnd_d = free_fnd_q; free_slot_d = free_slot_q;
    cnt_d = cnt_q;       pair_d = pair_q;     cand_d = cand_q;
    prior_d = prior_q;   list_d = list_q;     rem_d = rem_q;
    best_vld_d = best_vld_q; best_slot_d = best_slot_q; best_k_d = best_k_q;
    best_snd_d = best_snd_q; best_rcv_d = best_rcv_q; best_ts_d = best_ts_q;
    emit_d = emit_q;
    mem_o = '0;
    push_o = 1'b0;
    res_o = '0;

    // Slot scans issue one read per cycle and check its data in the following cycle.
    if (state_q == SWScan || state_q == SQScan || state_q == SGScan) begin
      if (slot_iss_more) begin
        mem_o.raddr = iss_q[SlotW-1:0];
        chk_vld_d   = 1'b1;
        iss_d       = iss_q + 1'b1;
      end
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          id_d = in_id_i; snd_d = in_snd_i; rcv_d = in_rcv_i; ts_d = in_ts_i;
          iss_d = '0; cnt_d = '0; pair_d = 1'b0; free_fnd_d = 1'b0;
          cand_d = '0;
          unique case (in_action_i)
            ActWrite: state_d = SWScan;
            ActQuery: state_d = SQScan;
            ActSweep: state_d = SGet;
            default:  state_d = SIdle;
          endcase
        end
      end
      SWScan: begin
        if (chk_vld_q && id_eff == '0 && !free_fnd_q) begin
          free_fnd_d  = 1'b1;
          free_slot_d = rd_addr_q;
        end
        if (!slot_iss_more && !chk_vld_q) state_d = SWStore;
      end
      SWStore: begin
        if (out_free_i) begin
          if (free_fnd_q) begin
            mem_o.id_we     = 1'b1;
            mem_o.dat_we    = 1'b1;
            mem_o.waddr     = free_slot_q;
            mem_o.id_wdata  = id_q;
            mem_o.dat_wdata = {snd_q, rcv_q, ts_q};
            vld_d[free_slot_q] = 1'b1;
          end
          push_o         = 1'b1;
          res_o.kind     = KindWrite;
          res_o.write_ok = free_fnd_q;
          res_o.last     = 1'b1;
          state_d        = SIdle;
        end
      end
      SQScan: begin
        if (chk_vld_q && id_eff == id_q) begin
          if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
          if (id_q != '0 && rd_rcv == rcv_q) pair_d = 1'b1;
        end
        if (!slot_iss_more && !chk_vld_q) state_d = SQDone;
      end
      SQDone: begin
        if (out_free_i) begin
          push_o             = 1'b1;
          res_o.kind         = KindQuery;
          res_o.id_count     = cnt_q;
          res_o.pair_present = pair_q;
          res_o.last         = 1'b1;
          state_d            = SIdle;
        end
      end
      SGet: begin
        mem_o.raddr = cand_q;
        state_d     = SGChk;
      end
      SGChk: begin
        if (id_eff == '0) begin
          if (cand_last) state_d = SEnd;
          else begin
            cand_d  = cand_q + 1'b1;
            state_d = SGet;
          end
        end else begin
          id_d    = id_eff;
          iss_d   = '0;
          cnt_d   = '0;
          prior_d = 1'b0;
          state_d = SGScan;
        end
      end
      SGScan: begin
        if (chk_vld_q && id_eff == id_q) begin
          if (rd_addr_q < cand_q) prior_d = 1'b1;
          if (cnt_q < CntW'(Devices)) list_d[cnt_q[DevIdxW-1:0]] = rd_addr_q;
          if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
        end
        if (!slot_iss_more && !chk_vld_q) begin
          if (!prior_q && cnt_q == CntW'(Devices)) begin
            iss_d      = '0;
            rem_d      = '1;
            best_vld_d = 1'b0;
            emit_d     = '0;
            state_d    = SSel;
          end else if (cand_last) begin
            state_d = SEnd;
          end else begin
            cand_d  = cand_q + 1'b1;
            state_d = SGet;
          end
        end
      end
      SSel: begin
        // Pick the newest remaining entry; strict compare keeps the lower slot.
        if (sel_iss_more) begin
          mem_o.raddr = list_q[iss_q[DevIdxW-1:0]];
          chk_vld_d   = 1'b1;
          chk_idx_d   = iss_q;
          iss_d       = iss_q + 1'b1;
        end
        if (chk_vld_q && rem_q[k_chk] && (!best_vld_q || rd_ts > best_ts_q)) begin
          best_vld_d  = 1'b1;
          best_slot_d = rd_addr_q;
          best_k_d    = k_chk;
          best_snd_d  = rd_snd;
          best_rcv_d  = rd_rcv;
          best_ts_d   = rd_ts;
        end
        if (!sel_iss_more && !chk_vld_q) state_d = SEmit;
      end
      SEmit: begin
        if (out_free_i) begin
          push_o            = 1'b1;
          res_o.kind        = KindGather;
          res_o.group_id    = id_q;
          res_o.sender      = best_snd_q;
          res_o.receiver    = best_rcv_q;
          res_o.timestamp   = best_ts_q;
          res_o.group_last  = emit_q == IssW'(Devices - 1);
          mem_o.id_we       = 1'b1;
          mem_o.waddr       = best_slot_q;
          rem_d[best_k_q]   = 1'b0;
          emit_d            = emit_q + 1'b1;
          iss_d             = '0;
          best_vld_d        = 1'b0;
          if (emit_q != IssW'(Devices - 1)) state_d = SSel;
          else if (cand_last) state_d = SEnd;
          else begin
            cand_d  = cand_q + 1'b1;
            state_d = SGet;
          end
        end
      end
      SEnd: begin
        if (out_free_i) begin
          push_o     = 1'b1;
          res_o.kind = KindEnd;
          res_o.last = 1'b1;
          state_d    = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      iss_q      <= '0;
      chk_vld_q  <= 1'b0;
      vld_q      <= '0;
      best_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_q      <= iss_d;
      chk_vld_q  <= chk_vld_d;
      vld_q      <= vld_d;
      best_vld_q <= best_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    rd_addr_q   <= mem_o.raddr;
    id_q        <= id_d;
    snd_q       <= snd_d;
    rcv_q       <= rcv_d;
    ts_q        <= ts_d;
    free_fnd_q  <= free_fnd_d;
    free_slot_q <= free_slot_d;
    cnt_q       <= cnt_d;
    pair_q      <= pair_d;
    cand_q      <= cand_d;
    prior_q     <= prior_d;
    list_q      <= list_d;
    rem_q       <= rem_d;
    best_slot_q <= best_slot_d;
    best_k_q    <= best_k_d;
    best_snd_q  <= best_snd_d;
    best_rcv_q  <= best_rcv_d;
    best_ts_q   <= best_ts_d;
    emit_q      <= emit_d;
  end

  `ASSERT_CLK(a_push_room, push_o |-> out_free_i, "result pushed into a full output")
  `ASSERT_CLK(a_emit_best, (state_q == SEmit) |-> best_vld_q, "gather without a chosen entry")
  `ASSERT_NEVER(a_we_scan, (mem_o.id_we || mem_o.dat_we) && chk_vld_q,
                "table write while a read is in flight")

endmodule

[hdl/ack_collection_table.sv]
// Top level of the ack collection table: stream ports, table RAMs, result register.
// Depends on act_pkg, act_ram, act_ctl and assert_macros.svh.
//
// Table of TableSlots acks held in two RAMs with registered reads (ids, and
// sender/receiver/timestamp), with a valid bit per slot so the id table reads
// free after reset without a clearing pass. One input word is taken at a time.
// A write or query walks every slot through the id RAM read port, and the next
// word is taken only once the block is back in idle. A sweep visits each slot
// as a candidate (states SGet and SGChk), and a live candidate id costs another
// scan of every slot; a completed group adds Devices selection passes plus one
// emit per ack, and the end marker comes last. A sweep also stalls while a
// result waits on the sink.
// Results go to a one-word output register, so the table keeps
// working while a word waits downstream until it has the next result ready.
`include "assert_macros.svh"
module ack_collection_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // msg_id[15:0], src_pid[37:16], dst_pid[59:38], timestamp[91:60]
  input  logic [act_pkg::InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // write_ok[0], id_count[5:1], pair_present[6], group_id[22:7],
  // out_sender[44:23], out_receiver[66:45], out_timestamp[98:67], group_last[99]
  output logic [act_pkg::OutDataW-1:0] m_axis_tdata,
  // result_kind
  output logic [1:0]                   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import act_pkg::*;

  mem_req_t        mem;
  logic [IdW-1:0]  id_rdata;
  logic [DatW-1:0] dat_rdata;
  logic            out_free, push;
  res_t            res, res_q;
  logic            out_vld_q;

  // Free the output register when empty or when its word leaves this cycle.
  assign out_free = !out_vld_q || m_axis_tready;

  act_ram #(.Width(IdW), .Depth(TableSlots)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (mem.id_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.id_wdata),
    .raddr_i (mem.raddr),
    .rdata_o (id_rdata)
  );

  act_ram #(.Width(DatW), .Depth(TableSlots)) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (mem.dat_we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.dat_wdata),
    .raddr_i (mem.raddr),
    .rdata_o (dat_rdata)
  );

  act_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_id_i     (s_axis_tdata[15:0]),
    .in_snd_i    (s_axis_tdata[37:16]),
    .in_rcv_i    (s_axis_tdata[59:38]),
    .in_ts_i     (s_axis_tdata[91:60]),
    .mem_o       (mem),
    .id_rdata_i  (id_rdata),
    .dat_rdata_i (dat_rdata),
    .out_free_i  (out_free),
    .push_o      (push),
    .res_o       (res)
  );

  // Hold the result word until the sink takes it; load a new one on push.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {4'b0, res_q.group_last, res_q.timestamp, res_q.receiver,
                          res_q.sender, res_q.group_id, res_q.pair_present,
                          res_q.id_count, res_q.write_ok};

  `ASSERT_CLK(a_busy_no_take, (s_axis_tready && out_vld_q && !m_axis_tready) |=> out_vld_q,
              "pending result word lost")
  `ASSERT_NEVER(a_push_on_full, push && out_vld_q && !m_axis_tready,
                "result pushed over a waiting word")

endmodule
